FILE: rtl/blclip_pkg.sv
`default_nettype none
package blclip_pkg;

    localparam int SIZE_BITS       = 14;
    localparam int MODE_BITS       = 4;
    localparam int CFG_IDX_BITS    = 1;
    localparam int COORD_BITS_DEF  = 16;

    localparam logic [SIZE_BITS-1:0] DST_WIDTH_RST  = 14'd1024;
    localparam logic [SIZE_BITS-1:0] DST_HEIGHT_RST = 14'd768;

    localparam logic [CFG_IDX_BITS-1:0] REG_DST_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_HEIGHT = 1'b1;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_en;

endpackage
`default_nettype wire

FILE: rtl/blclip_ctl.sv
`default_nettype none
module blclip_ctl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output blclip_pkg::t_pipe_en o_en
);

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !r_v3 || i_out_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_en.en1   = rdy1;
    assign o_en.en2   = rdy2;
    assign o_en.en3   = rdy3;
    assign o_in_ready  = rdy1;
    assign o_out_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/blclip_axis.sv
`default_nettype none
module blclip_axis #(
    parameter int COORD_BITS = blclip_pkg::COORD_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire  blclip_pkg::t_pipe_en           i_en,
    input  wire                                  i_area,
    input  wire  [blclip_pkg::SIZE_BITS-1:0]     i_size,
    input  wire  [blclip_pkg::SIZE_BITS-1:0]     i_dst,
    input  wire  signed [COORD_BITS-1:0]         i_org,
    input  wire  signed [COORD_BITS-1:0]         i_len,
    input  wire  signed [COORD_BITS-1:0]         i_pt,
    output logic                                 o_ok,
    output logic [blclip_pkg::SIZE_BITS-1:0]     o_org,
    output logic [blclip_pkg::SIZE_BITS-1:0]     o_len,
    output logic [blclip_pkg::SIZE_BITS-1:0]     o_pt
);

    localparam int SB = blclip_pkg::SIZE_BITS;
    localparam int AW = ((COORD_BITS > SB + 1) ? COORD_BITS : SB + 1) + 3;

    logic signed [AW-1:0] sw_in, dw_e, o0, w0, d0;
    logic                 rej1;
    logic signed [AW-1:0] n_o1, n_w1, n_d1;

    logic                 r1_ok, r1_area;
    logic [SB-1:0]        r1_sw;
    logic signed [AW-1:0] r1_o, r1_w, r1_d;

    logic signed [AW-1:0] wa, n_o2, n_w2, n_d2;

    logic                 r2_ok, r2_area;
    logic [SB-1:0]        r2_sw;
    logic signed [AW-1:0] r2_o, r2_w, r2_d;

    logic signed [AW-1:0] sw2, n_w3;

    logic                 r3_ok;
    logic [SB-1:0]        r3_o, r3_w, r3_d;

    assign dw_e  = $signed({{(AW-SB){1'b0}}, i_dst});
    assign sw_in = $signed({{(AW-SB){1'b0}}, i_size});

    // stage 1: pick rectangle, reject tests, clip destination left/top
    always_comb begin
        o0 = i_area ? AW'(i_org) : '0;
        w0 = i_area ? AW'(i_len) : sw_in;
        d0 = AW'(i_pt);
        rej1 = (i_area && (o0 >= sw_in)) || (d0 > dw_e) || (d0 + w0 <= 0);
        if (d0 < 0) begin
            n_o1 = o0 - d0;
            n_w1 = w0 + d0;
            n_d1 = '0;
        end else begin
            n_o1 = o0;
            n_w1 = w0;
            n_d1 = d0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r1_ok   <= !rej1;
            r1_area <= i_area;
            r1_sw   <= i_size;
            r1_o    <= n_o1;
            r1_w    <= n_w1;
            r1_d    <= n_d1;
        end
    end

    // stage 2: trim right/bottom, then clip negative source origin
    always_comb begin
        wa  = (r1_d + r1_w > dw_e) ? dw_e - r1_d : r1_w;
        if (r1_area && (r1_o < 0)) begin
            n_w2 = wa + r1_o;
            n_d2 = r1_d - r1_o;
            n_o2 = '0;
        end else begin
            n_w2 = wa;
            n_d2 = r1_d;
            n_o2 = r1_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r2_ok   <= r1_ok;
            r2_area <= r1_area;
            r2_sw   <= r1_sw;
            r2_o    <= n_o2;
            r2_w    <= n_w2;
            r2_d    <= n_d2;
        end
    end

    // stage 3: trim source overshoot, empty test
    always_comb begin
        sw2  = $signed({{(AW-SB){1'b0}}, r2_sw});
        n_w3 = (r2_area && (r2_o + r2_w - sw2 > 0)) ? sw2 - r2_o : r2_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r3_ok <= r2_ok && (n_w3 > 0);
            r3_o  <= r2_o[SB-1:0];
            r3_w  <= n_w3[SB-1:0];
            r3_d  <= r2_d[SB-1:0];
        end
    end

    assign o_ok  = r3_ok;
    assign o_org = r3_o;
    assign o_len = r3_w;
    assign o_pt  = r3_d;

endmodule
`default_nettype wire

FILE: rtl/blit_rectangle_clipper.sv
// Blit rectangle clipper.
// Input channel: i_in_valid / o_in_ready carry one blit request item
// (source size, optional source rectangle, destination point, mode).
// Output channel: o_out_valid / i_out_ready carry one result item per
// request: o_blit_valid, the clipped source rectangle, the clipped
// destination point and the mode. A rejected request gives
// o_blit_valid = 0 with all geometry fields 0.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 = destination width, 1 = destination height); write only when idle.
// Pipeline: each request passes through the three register stages of the
// per-axis clip pipeline (x and y run in parallel); o_out_valid is the
// valid bit of the last stage.
// Throughput: one item per cycle while i_out_ready does not stall the output.
// Reset (synchronous, active low) empties the pipeline and loads the
// destination size 1024 x 768.
// Stall: while i_out_ready is low the result holds; items keep entering
// until every stage is full, then o_in_ready drops. Nothing is lost.
`default_nettype none
module blit_rectangle_clipper #(
    parameter int COORD_BITS = blclip_pkg::COORD_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [blclip_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire  [blclip_pkg::SIZE_BITS-1:0]      i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  [blclip_pkg::SIZE_BITS-1:0]      i_src_width,
    input  wire  [blclip_pkg::SIZE_BITS-1:0]      i_src_height,
    input  wire                                   i_has_area,
    input  wire  signed [COORD_BITS-1:0]          i_area_x,
    input  wire  signed [COORD_BITS-1:0]          i_area_y,
    input  wire  signed [COORD_BITS-1:0]          i_area_w,
    input  wire  signed [COORD_BITS-1:0]          i_area_h,
    input  wire  signed [COORD_BITS-1:0]          i_dest_x,
    input  wire  signed [COORD_BITS-1:0]          i_dest_y,
    input  wire  [blclip_pkg::MODE_BITS-1:0]      i_blit_mode,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_blit_valid,
    output logic [blclip_pkg::SIZE_BITS-1:0]      o_clip_src_x,
    output logic [blclip_pkg::SIZE_BITS-1:0]      o_clip_src_y,
    output logic [blclip_pkg::SIZE_BITS-1:0]      o_clip_w,
    output logic [blclip_pkg::SIZE_BITS-1:0]      o_clip_h,
    output logic [blclip_pkg::SIZE_BITS-1:0]      o_clip_dest_x,
    output logic [blclip_pkg::SIZE_BITS-1:0]      o_clip_dest_y,
    output logic [blclip_pkg::MODE_BITS-1:0]      o_mode_out
);

    localparam int SB = blclip_pkg::SIZE_BITS;
    localparam int MB = blclip_pkg::MODE_BITS;

    logic [SB-1:0] r_dst_width, r_dst_height;
    logic [MB-1:0] r_mode1, r_mode2, r_mode3;

    blclip_pkg::t_pipe_en w_en;

    logic          ok_x, ok_y, ok;
    logic [SB-1:0] x_org, x_len, x_pt, y_org, y_len, y_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_width  <= blclip_pkg::DST_WIDTH_RST;
            r_dst_height <= blclip_pkg::DST_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                blclip_pkg::REG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                blclip_pkg::REG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    blclip_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_en        (w_en)
    );

    blclip_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_area (i_has_area),
        .i_size (i_src_width),
        .i_dst  (r_dst_width),
        .i_org  (i_area_x),
        .i_len  (i_area_w),
        .i_pt   (i_dest_x),
        .o_ok   (ok_x),
        .o_org  (x_org),
        .o_len  (x_len),
        .o_pt   (x_pt)
    );

    blclip_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_area (i_has_area),
        .i_size (i_src_height),
        .i_dst  (r_dst_height),
        .i_org  (i_area_y),
        .i_len  (i_area_h),
        .i_pt   (i_dest_y),
        .o_ok   (ok_y),
        .o_org  (y_org),
        .o_len  (y_len),
        .o_pt   (y_pt)
    );

    always_ff @(posedge i_clk) begin
        if (w_en.en1) r_mode1 <= i_blit_mode;
        if (w_en.en2) r_mode2 <= r_mode1;
        if (w_en.en3) r_mode3 <= r_mode2;
    end

    assign ok            = ok_x && ok_y;
    assign o_blit_valid  = ok;
    assign o_clip_src_x  = ok ? x_org : '0;
    assign o_clip_src_y  = ok ? y_org : '0;
    assign o_clip_w      = ok ? x_len : '0;
    assign o_clip_h      = ok ? y_len : '0;
    assign o_clip_dest_x = ok ? x_pt  : '0;
    assign o_clip_dest_y = ok ? y_pt  : '0;
    assign o_mode_out    = r_mode3;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

    a_valid_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_blit_valid) |-> (o_clip_w != '0 && o_clip_h != '0))
        else $error("valid blit with empty size");
`endif

endmodule
`default_nettype wire
